// ===== rtl/lft_pkg.sv =====
// lft_pkg: shared constants, controller/datapath command and status types,
// and the letter fold function of the letter fold tokenizer.
// No dependencies.
package lft_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int CP_W              = 21;
    localparam int CHAR_W            = 8;
    localparam int WORD_CHARS        = 8;
    localparam int CNT_W             = 4;

    localparam logic [CP_W-1:0] UPPER_LO  = CP_W'(32'h41);
    localparam logic [CP_W-1:0] UPPER_HI  = CP_W'(32'h5A);
    localparam logic [CP_W-1:0] LOWER_LO  = CP_W'(32'h61);
    localparam logic [CP_W-1:0] LOWER_HI  = CP_W'(32'h7A);
    localparam logic [CP_W-1:0] LATIN1_LO = CP_W'(32'hC0);
    localparam logic [CP_W-1:0] LATIN1_HI = CP_W'(32'hFF);
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    // first character sits in the top byte
    localparam logic [64*CHAR_W-1:0] FOLD_STR =
        "aaaaaaeceeeeiiiidnoooooxouuuuypsaaaaaaeceeeeiiiionooooooouuuuypy";

    typedef struct packed {
        logic append;   // store the folded letter of the accepted item
        logic clear;    // drop the pending token, restart the word counter
        logic rd;       // read the buffer word at the word counter
        logic load;     // move the current word into the output register
    } lft_cmd_t;

    typedef struct packed {
        logic is_letter;
        logic eot;
        logic tok_ok;     // length after this item is 1..max
        logic last_word;  // word counter points at the final word
        logic out_free;   // output register can take a word
    } lft_status_t;

    // returns 0 for a delimiter
    function automatic logic [CHAR_W-1:0] fold_letter(input logic [CP_W-1:0] cp);
        logic [5:0] ridx;
        logic [CHAR_W-1:0] ch;
        ridx = ~cp[5:0];
        ch   = '0;
        if (cp >= UPPER_LO && cp <= UPPER_HI)
            ch = cp[CHAR_W-1:0] + CASE_OFS;
        else if (cp >= LOWER_LO && cp <= LOWER_HI)
            ch = cp[CHAR_W-1:0];
        else if (cp >= LATIN1_LO && cp <= LATIN1_HI)
            ch = FOLD_STR[{ridx, 3'b000} +: CHAR_W];
        return ch;
    endfunction

endpackage

// ===== rtl/lft_if.sv =====
// lft_in_if / lft_out_if: valid/ready channels of the letter fold tokenizer.
// Depends on lft_pkg.
interface lft_in_if
    import lft_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            end_of_text;

    modport source (output valid, output code_point, output end_of_text, input ready);
    modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

interface lft_out_if
    import lft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_0;
    logic [CHAR_W-1:0] char_1;
    logic [CHAR_W-1:0] char_2;
    logic [CHAR_W-1:0] char_3;
    logic [CHAR_W-1:0] char_4;
    logic [CHAR_W-1:0] char_5;
    logic [CHAR_W-1:0] char_6;
    logic [CHAR_W-1:0] char_7;
    logic [CNT_W-1:0]  char_count;
    logic              last_of_token;

    modport source (output valid, output char_0, output char_1, output char_2,
                    output char_3, output char_4, output char_5, output char_6,
                    output char_7, output char_count, output last_of_token,
                    input ready);
    modport sink   (input valid, input char_0, input char_1, input char_2,
                    input char_3, input char_4, input char_5, input char_6,
                    input char_7, input char_count, input last_of_token,
                    output ready);
endinterface

// ===== rtl/letter_fold_tokenizer_unit.sv =====
// letter_fold_tokenizer_unit: top level; joins the controller and datapath
// to the input and output channels.
// Depends on lft_pkg, lft_if, lft_ctrl, lft_dp.
//
// Usage: the text channel takes one decoded code point per item with an
// end_of_text flag. Letters (A-Z, a-z, U+00C0..U+00FF) are folded to ASCII
// lowercase and stored; any other code point ends the pending token, and so
// does an item with end_of_text set (after its own letter, if it is one).
// A finished token of 1..MAX_TOKEN_LEN letters leaves on the tokens channel
// as words of up to eight letters, last_of_token set on the final word;
// longer tokens are dropped without any output.
// A letter, or a delimiter that ends no token, leaves the controller in IDLE
// with text.ready high. Each word of a finished token is read from the token
// buffer RAM (FETCH) and then loaded into the output register (LOAD).
// text.ready stays low from the ending item until the last word is loaded;
// the last word may still wait in the output register while the next item
// is taken.
// When the receiver stalls the output register holds its word and emission
// pauses. Reset empties the pending token and the output register; the
// buffer RAM is not cleared.
module letter_fold_tokenizer_unit
    import lft_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input logic       clk,
    input logic       rst_n,
    lft_in_if.sink    text,
    lft_out_if.source tokens
);
    lft_cmd_t          cmd;
    lft_status_t       status;
    logic [CHAR_W-1:0] out_char [WORD_CHARS];

    lft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (text.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lft_dp #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .code_point  (text.code_point),
        .end_of_text (text.end_of_text),
        .out_ready   (tokens.ready),
        .out_valid   (tokens.valid),
        .out_char    (out_char),
        .out_count   (tokens.char_count),
        .out_last    (tokens.last_of_token)
    );

    assign tokens.char_0 = out_char[0];
    assign tokens.char_1 = out_char[1];
    assign tokens.char_2 = out_char[2];
    assign tokens.char_3 = out_char[3];
    assign tokens.char_4 = out_char[4];
    assign tokens.char_5 = out_char[5];
    assign tokens.char_6 = out_char[6];
    assign tokens.char_7 = out_char[7];
endmodule

// ===== rtl/lft_ram.sv =====
// lft_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module lft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/lft_dp.sv =====
// lft_dp: datapath of the tokenizer: letter fold, token length, partial word,
// token word buffer and output register.
// Depends on lft_pkg and lft_ram.
module lft_dp
    import lft_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lft_cmd_t          cmd,
    output lft_status_t       status,
    input  logic [CP_W-1:0]   code_point,
    input  logic              end_of_text,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [CHAR_W-1:0] out_char [WORD_CHARS],
    output logic [CNT_W-1:0]  out_count,
    output logic              out_last
);
    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 2);
    localparam int IDX_W  = LEN_W - 3;
    localparam int WORDS  = (MAX_TOKEN_LEN + WORD_CHARS - 1) / WORD_CHARS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [LEN_W-1:0] MAX_L  = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] OVER_L = LEN_W'(MAX_TOKEN_LEN + 1);

    logic [LEN_W-1:0]  len_reg, len_next, len_app, len_m1;
    logic [IDX_W-1:0]  wcnt_reg, wcnt_next;
    logic [CHAR_W-1:0] word_reg [WORD_CHARS];
    logic [CHAR_W-1:0] ch;
    logic              room;
    logic              ram_we;
    logic [WORD_CHARS*CHAR_W-1:0] ram_wdata, ram_rdata;
    logic              from_reg;
    logic [CNT_W-1:0]  cnt;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg [WORD_CHARS];
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_last_reg;

    assign ch      = fold_letter(code_point);
    assign room    = (len_reg < MAX_L);
    assign len_app = (ch != '0) ? (room ? len_reg + LEN_W'(1) : OVER_L) : len_reg;
    assign len_m1  = len_reg - LEN_W'(1);

    assign status.is_letter = (ch != '0);
    assign status.eot       = end_of_text;
    assign status.tok_ok    = (len_app != '0) && (len_app <= MAX_L);
    assign status.last_word = (wcnt_reg == len_m1[LEN_W-1:3]);
    assign status.out_free  = !out_valid_reg || out_ready;

    // full word goes to the buffer when its eighth letter arrives
    assign ram_we = cmd.append && room && (len_reg[2:0] == 3'd7);
    always_comb
    begin
        for (int j = 0; j < WORD_CHARS; j++)
        begin
            ram_wdata[j*CHAR_W +: CHAR_W] = (j == WORD_CHARS - 1) ? ch : word_reg[j];
        end
    end

    lft_ram #(
        .WIDTH (WORD_CHARS * CHAR_W),
        .DEPTH (WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[ADDR_W+2:3]),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (wcnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // a trailing partial word never left the assembly register
    assign from_reg = (wcnt_reg == len_reg[LEN_W-1:3]);
    assign cnt = status.last_word ? ({1'b0, len_m1[2:0]} + CNT_W'(1)) : CNT_W'(WORD_CHARS);

    always_comb
    begin
        len_next  = len_reg;
        wcnt_next = wcnt_reg;
        if (cmd.clear)
        begin
            len_next  = '0;
            wcnt_next = '0;
        end
        else
        begin
            if (cmd.append)
                len_next = len_app;
            if (cmd.load)
                wcnt_next = wcnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            wcnt_reg <= wcnt_next;
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && room)
        begin
            word_reg[len_reg[2:0]] <= ch;
        end
        if (cmd.load)
        begin
            for (int j = 0; j < WORD_CHARS; j++)
            begin
                if (CNT_W'(j) < cnt)
                    out_char_reg[j] <= from_reg ? word_reg[j] : ram_rdata[j*CHAR_W +: CHAR_W];
                else
                    out_char_reg[j] <= '0;
            end
            out_count_reg <= cnt;
            out_last_reg  <= status.last_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;
endmodule

// ===== rtl/lft_ctrl.sv =====
// lft_ctrl: controller state machine of the tokenizer; sequences letter
// appends and the word-by-word emission of a finished token.
// Depends on lft_pkg.
module lft_ctrl
    import lft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  lft_status_t status,
    output lft_cmd_t    cmd
);
    typedef enum logic [1:0] {
        IDLE,
        FETCH,
        LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   flush;

    assign in_ready = (state_reg == IDLE);
    assign accept   = in_valid && in_ready;
    assign flush    = !status.is_letter || status.eot;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd.append = status.is_letter;
                    if (flush)
                    begin
                        if (status.tok_ok)
                            state_next = FETCH;
                        else
                            cmd.clear = 1'b1;
                    end
                end
            end
            FETCH:
            begin
                cmd.rd     = 1'b1;
                state_next = LOAD;
            end
            LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.last_word)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = IDLE;
                    end
                    else
                    begin
                        state_next = FETCH;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== rtl/lft_chk.sv =====
// lft_chk: port-level checks of the tokenizer, bound to the top level.
// No package dependency.
module lft_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_1,
    input logic [7:0] char_7,
    input logic [3:0] char_count,
    input logic       last_of_token
);
    // a stalled word stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_count >= 4'd1 && char_count <= 4'd8)
        else $error("char_count out of range");

    // char_7, and char_1 when the count is one, read as zero past the count
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_count < 4'd8 |-> char_7 == 8'd0 &&
            (char_count != 4'd1 || char_1 == 8'd0))
        else $error("unused letter not zero");

    // no new item while a token is half emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_token |-> !in_ready)
        else $error("input taken during token emission");
endmodule

bind letter_fold_tokenizer_unit lft_chk u_lft_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (text.ready),
    .out_valid     (tokens.valid),
    .out_ready     (tokens.ready),
    .char_1        (tokens.char_1),
    .char_7        (tokens.char_7),
    .char_count    (tokens.char_count),
    .last_of_token (tokens.last_of_token)
);

// ===== verif/letter_fold_tokenizer_unit_test.sv =====
// letter_fold_tokenizer_unit_test: self-checking bench for the letter fold tokenizer.
// Drives code point items, predicts the token words and compares each one that leaves.
// Depends on lft_pkg, lft_if and letter_fold_tokenizer_unit.
`timescale 1ns / 1ps

module letter_fold_tokenizer_unit_test;
    import lft_pkg::*;

    localparam int MAX_LEN      = MAX_TOKEN_LEN_DEF;
    localparam int IDLE_PERCENT = 28;
    localparam int DRAIN_LIMIT  = 20000;

    // fold of U+00C0..U+00FF, entry 0 first
    localparam logic [0:63][7:0] FOLD_MAP =
        "aaaaaaeceeeeiiiidnoooooxouuuuypsaaaaaaeceeeeiiiionooooooouuuuypy";

    typedef struct packed {
        logic [0:7][CHAR_W-1:0] letters;
        logic [CNT_W-1:0]       count;
        logic                   last;
    } token_word_t;

    logic clk;
    logic rst_n;

    lft_in_if  text();
    lft_out_if tokens();

    letter_fold_tokenizer_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .tokens (tokens)
    );

    // predictor state
    logic [CHAR_W-1:0] held_letters [MAX_LEN];
    int                held_count;
    token_word_t       pending_words [$];

    int  items_sent;
    int  tokens_predicted;
    int  words_checked;
    int  error_count;
    bit  steady;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("[letter_fold_tokenizer_unit] ERROR");
        $finish;
    end

    // receiver side: random stalls unless in a steady stretch
    initial
    begin
        tokens.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tokens.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    function automatic logic [CHAR_W-1:0] fold_to_letter(logic [CP_W-1:0] cp);
        if (cp >= UPPER_LO && cp <= UPPER_HI)
            return cp[CHAR_W-1:0] + 8'h20;
        if (cp >= LOWER_LO && cp <= LOWER_HI)
            return cp[CHAR_W-1:0];
        if (cp >= LATIN1_LO && cp <= LATIN1_HI)
            return FOLD_MAP[cp[5:0]];
        return '0;
    endfunction

    // split the held token into words; overflowed or empty tokens give nothing
    function automatic void release_token();
        token_word_t w;
        int pos;
        int n;
        if (held_count >= 1 && held_count <= MAX_LEN)
        begin
            pos = 0;
            while (pos < held_count)
            begin
                n = (held_count - pos > 8) ? 8 : held_count - pos;
                w = '0;
                for (int j = 0; j < n; j++)
                    w.letters[j] = held_letters[pos + j];
                w.count = CNT_W'(n);
                pos += n;
                w.last = (pos >= held_count);
                pending_words.insert(pending_words.size(), w);
            end
            tokens_predicted++;
        end
        held_count = 0;
    endfunction

    function automatic void absorb_code_point(logic [CP_W-1:0] cp, logic eot);
        logic [CHAR_W-1:0] ch;
        ch = fold_to_letter(cp);
        if (ch != '0)
        begin
            if (held_count < MAX_LEN)
            begin
                held_letters[held_count] = ch;
                held_count++;
            end
            else
                held_count = MAX_LEN + 1;
        end
        else
            release_token();
        if (eot)
            release_token();
    endfunction

    // one item on the text channel; valid stays high until the next gap or item
    task automatic send_code_point(logic [CP_W-1:0] cp, logic eot);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            text.valid <= 1'b0;
        end
        @(negedge clk);
        text.valid       <= 1'b1;
        text.code_point  <= cp;
        text.end_of_text <= eot;
        do
            @(posedge clk);
        while (text.ready !== 1'b1);
        absorb_code_point(cp, eot);
        items_sent++;
    endtask

    function automatic logic [CP_W-1:0] random_letter();
        case ($urandom_range(0, 2))
            0: return CP_W'(32'h41 + $urandom_range(0, 25));
            1: return CP_W'(32'h61 + $urandom_range(0, 25));
            default: return CP_W'(32'hC0 + $urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] random_delimiter();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 7))
            0: cp = CP_W'(32'h20);
            1: cp = CP_W'($urandom_range(32'h30, 32'h39));
            2: cp = CP_W'($urandom_range(32'h00, 32'h40));
            3: cp = CP_W'($urandom_range(32'h5B, 32'h60));
            4: cp = CP_W'($urandom_range(32'h7B, 32'hBF));
            5: cp = CP_W'($urandom_range(32'hD800, 32'hDFFF));
            6: cp = CP_W'($urandom_range(32'h110000, 32'h1FFFFF));
            default: cp = CP_W'($urandom);
        endcase
        while (fold_to_letter(cp) != '0)
            cp = CP_W'($urandom);
        return cp;
    endfunction

    task automatic send_word(int len, logic eot_on_last);
        for (int i = 0; i < len; i++)
            send_code_point(random_letter(), eot_on_last && (i == len - 1));
    endtask

    // letter and range edges, table oddities, end of text on letters and delimiters
    task automatic test_directed();
        send_code_point(CP_W'(32'h41), 1'b0);
        send_code_point(CP_W'(32'h5A), 1'b0);
        send_code_point(CP_W'(32'h61), 1'b0);
        send_code_point(CP_W'(32'h7A), 1'b0);
        send_code_point(CP_W'(32'hC0), 1'b0);
        send_code_point(CP_W'(32'hD7), 1'b0);
        send_code_point(CP_W'(32'hF7), 1'b0);
        send_code_point(CP_W'(32'hFF), 1'b0);
        send_code_point(CP_W'(32'h40), 1'b0);
        send_code_point(CP_W'(32'h5B), 1'b0);
        send_code_point(CP_W'(32'h60), 1'b0);
        send_code_point(CP_W'(32'h7B), 1'b0);
        send_code_point(CP_W'(32'hBF), 1'b0);
        send_code_point(CP_W'(32'h100), 1'b0);
        send_code_point(CP_W'(32'h42), 1'b0);
        send_code_point(CP_W'(32'hE9), 1'b0);
        send_code_point(CP_W'(32'h63), 1'b1);
        send_code_point(CP_W'(32'h0), 1'b1);
        send_code_point(CP_W'(32'h10FFFF), 1'b0);
        send_code_point(CP_W'(32'hD800), 1'b0);
        send_code_point(CP_W'(32'h44), 1'b0);
        send_code_point(CP_W'(32'h1FFFFF), 1'b1);
        send_code_point(CP_W'(32'h39), 1'b0);
    endtask

    // longest token kept, and overlong tokens, one past it and more, that must vanish
    task automatic test_token_limits();
        send_word(MAX_LEN, 1'b0);
        send_code_point(random_delimiter(), 1'b0);
        send_word(MAX_LEN + 1, 1'b1);
        send_word(MAX_LEN, 1'b1);
        send_word(MAX_LEN + 45, 1'b0);
        send_code_point(random_delimiter(), 1'b1);
        send_word(3, 1'b0);
        send_code_point(random_delimiter(), 1'b0);
    endtask

    // random words split by runs of delimiters, end of text now and then
    task automatic test_random_text(int item_budget);
        int stop_at;
        int len;
        int pick;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                len = $urandom_range(1, 12);
            else if (pick < 90)
                len = $urandom_range(13, 40);
            else
                len = 0;
            send_word(len, $urandom_range(0, 99) < 8);
            repeat ($urandom_range(1, 3))
                send_code_point(random_delimiter(), $urandom_range(0, 99) < 5);
        end
    endtask

    // word checker
    always @(posedge clk)
    begin
        token_word_t got;
        token_word_t want;
        if (rst_n && tokens.valid && tokens.ready)
        begin
            got.letters = {tokens.char_0, tokens.char_1, tokens.char_2, tokens.char_3,
                           tokens.char_4, tokens.char_5, tokens.char_6, tokens.char_7};
            got.count   = tokens.char_count;
            got.last    = tokens.last_of_token;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, got %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                for (int j = 0; j < 8; j++)
                    if (got.letters[j] !== want.letters[j])
                    begin
                        $display("%0t: char_%0d expected %h got %h", $time, j,
                                 want.letters[j], got.letters[j]);
                        error_count++;
                    end
                if (got.count !== want.count)
                begin
                    $display("%0t: char_count expected %0d got %0d", $time,
                             want.count, got.count);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last_of_token expected %b got %b", $time,
                             want.last, got.last);
                    error_count++;
                end
            end
            words_checked++;
        end
    end

    initial
    begin
        held_count       = 0;
        items_sent       = 0;
        tokens_predicted = 0;
        words_checked    = 0;
        error_count      = 0;
        steady           = 1'b0;
        rst_n            = 1'b0;
        text.valid       = 1'b0;
        text.code_point  = '0;
        text.end_of_text = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_token_limits();
        steady = 1'b1;
        test_random_text(60);
        steady = 1'b0;
        test_random_text(100);

        @(negedge clk);
        text.valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && pending_words.size() > 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_words.size() > 0)
        begin
            $display("%0t: %0d words never arrived", $time, pending_words.size());
            error_count++;
        end

        $display("sent %0d code points, %0d tokens predicted, %0d words checked",
                 items_sent, tokens_predicted, words_checked);
        $display("covered range edges, fold table, end of text, max and overlong tokens");
        if (error_count == 0)
            $display("[letter_fold_tokenizer_unit] OK");
        else
            $display("[letter_fold_tokenizer_unit] ERROR");
        $finish;
    end

endmodule
